// File: src/determinant_4x4_macros.svh
// assertion macros shared by the determinant block
`ifndef DETERMINANT_4X4_MACROS_SVH
`define DETERMINANT_4X4_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DET4_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication
`define DET4_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define DET4_ASSERT_IMPL(name, clk, rst, ante, cons)
`define DET4_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: src/det4_pkg.sv
`default_nettype none

package det4_pkg;

   // element and result widths
   localparam int ELEMENT_WIDTH = 14;
   localparam int DET_WIDTH     = 58;

   // intermediate widths: 2x2 and 3x3 minors (one scratch width), product, accumulator
   localparam int TMP_WIDTH  = 3 * ELEMENT_WIDTH + 1;
   localparam int PROD_WIDTH = ELEMENT_WIDTH + TMP_WIDTH;
   localparam int ACC_WIDTH  = 4 * ELEMENT_WIDTH + 2;

   // matrix store and scratch registers
   localparam int NUM_ELEMENTS  = 16;
   localparam int ADDR_WIDTH    = $clog2(NUM_ELEMENTS);
   localparam int NUM_TMPS      = 10;
   localparam int TMP_IDX_WIDTH = $clog2(NUM_TMPS);

   // microcode length
   localparam int NUM_STEPS  = 28;
   localparam int STEP_WIDTH = $clog2(NUM_STEPS);

   // control for the shared multiply-accumulate unit
   typedef struct packed {
      logic valid;
      logic first;
      logic subtract;
   } mac_ctl_type;

   // one microcode step
   typedef struct packed {
      logic                     valid;
      logic [ADDR_WIDTH-1:0]    x_addr;
      logic [ADDR_WIDTH-1:0]    y_addr;
      logic                     y_tmp;
      logic                     subtract;
      logic                     first;
      logic                     last;
      logic [TMP_IDX_WIDTH-1:0] dest;
      logic                     finish;
   } step_ctl_type;

   function automatic step_ctl_type make_step(input int x, input int y, input logic y_tmp,
                                              input logic sub, input logic first,
                                              input logic last, input int dest,
                                              input logic finish);
      step_ctl_type s;
      s.valid    = 1'b1;
      s.x_addr   = ADDR_WIDTH'(x);
      s.y_addr   = ADDR_WIDTH'(y);
      s.y_tmp    = y_tmp;
      s.subtract = sub;
      s.first    = first;
      s.last     = last;
      s.dest     = TMP_IDX_WIDTH'(dest);
      s.finish   = finish;
      return s;
   endfunction

   // schedule: six 2x2 minors of rows 2..3 (scratch 0..5: cols 01 02 03 12 13 23),
   // four 3x3 minors of rows 1..3 (scratch 6..9: skipped column 3 2 1 0),
   // then the expansion along row 0; each minor is read at least three
   // steps after the step that finishes it
   function automatic step_ctl_type step_code(input logic [STEP_WIDTH-1:0] step);
      step_ctl_type s;
      s = '0;
      unique case (step)
         // 2x2 minors: a2q*a3r - a2r*a3q
         5'd0:  s = make_step( 8, 13, 1'b0, 1'b0, 1'b1, 1'b0, 0, 1'b0);
         5'd1:  s = make_step( 9, 12, 1'b0, 1'b1, 1'b0, 1'b1, 0, 1'b0);
         5'd2:  s = make_step( 8, 14, 1'b0, 1'b0, 1'b1, 1'b0, 1, 1'b0);
         5'd3:  s = make_step(10, 12, 1'b0, 1'b1, 1'b0, 1'b1, 1, 1'b0);
         5'd4:  s = make_step( 8, 15, 1'b0, 1'b0, 1'b1, 1'b0, 2, 1'b0);
         5'd5:  s = make_step(11, 12, 1'b0, 1'b1, 1'b0, 1'b1, 2, 1'b0);
         5'd6:  s = make_step( 9, 14, 1'b0, 1'b0, 1'b1, 1'b0, 3, 1'b0);
         5'd7:  s = make_step(10, 13, 1'b0, 1'b1, 1'b0, 1'b1, 3, 1'b0);
         5'd8:  s = make_step( 9, 15, 1'b0, 1'b0, 1'b1, 1'b0, 4, 1'b0);
         5'd9:  s = make_step(11, 13, 1'b0, 1'b1, 1'b0, 1'b1, 4, 1'b0);
         5'd10: s = make_step(10, 15, 1'b0, 1'b0, 1'b1, 1'b0, 5, 1'b0);
         5'd11: s = make_step(11, 14, 1'b0, 1'b1, 1'b0, 1'b1, 5, 1'b0);
         // minor without column 3: a10*s12 - a11*s02 + a12*s01
         5'd12: s = make_step( 4, 3, 1'b1, 1'b0, 1'b1, 1'b0, 6, 1'b0);
         5'd13: s = make_step( 5, 1, 1'b1, 1'b1, 1'b0, 1'b0, 6, 1'b0);
         5'd14: s = make_step( 6, 0, 1'b1, 1'b0, 1'b0, 1'b1, 6, 1'b0);
         // minor without column 2: a10*s13 - a11*s03 + a13*s01
         5'd15: s = make_step( 4, 4, 1'b1, 1'b0, 1'b1, 1'b0, 7, 1'b0);
         5'd16: s = make_step( 5, 2, 1'b1, 1'b1, 1'b0, 1'b0, 7, 1'b0);
         5'd17: s = make_step( 7, 0, 1'b1, 1'b0, 1'b0, 1'b1, 7, 1'b0);
         // minor without column 1: a10*s23 - a12*s03 + a13*s02
         5'd18: s = make_step( 4, 5, 1'b1, 1'b0, 1'b1, 1'b0, 8, 1'b0);
         5'd19: s = make_step( 6, 2, 1'b1, 1'b1, 1'b0, 1'b0, 8, 1'b0);
         5'd20: s = make_step( 7, 1, 1'b1, 1'b0, 1'b0, 1'b1, 8, 1'b0);
         // minor without column 0: a11*s23 - a12*s13 + a13*s12
         5'd21: s = make_step( 5, 5, 1'b1, 1'b0, 1'b1, 1'b0, 9, 1'b0);
         5'd22: s = make_step( 6, 4, 1'b1, 1'b1, 1'b0, 1'b0, 9, 1'b0);
         5'd23: s = make_step( 7, 3, 1'b1, 1'b0, 1'b0, 1'b1, 9, 1'b0);
         // expansion along row 0 with alternating signs
         5'd24: s = make_step( 3, 6, 1'b1, 1'b1, 1'b1, 1'b0, 0, 1'b0);
         5'd25: s = make_step( 2, 7, 1'b1, 1'b0, 1'b0, 1'b0, 0, 1'b0);
         5'd26: s = make_step( 1, 8, 1'b1, 1'b1, 1'b0, 1'b0, 0, 1'b0);
         5'd27: s = make_step( 0, 9, 1'b1, 1'b0, 1'b0, 1'b1, 0, 1'b1);
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: src/det4_mac.sv
`default_nettype none

module det4_mac
   import det4_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic signed [ELEMENT_WIDTH-1:0] x,
   input  wire logic signed [TMP_WIDTH-1:0]  y,
   input  wire mac_ctl_type                  ctl,
   output logic signed [ACC_WIDTH-1:0]       acc
);

   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;
   mac_ctl_type                  ctl_ff;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic signed [ACC_WIDTH-1:0]  acc_in;
   logic signed [ACC_WIDTH-1:0]  base;
   logic signed [ACC_WIDTH-1:0]  prod_ext;

   // full-width signed product
   assign prod_in = PROD_WIDTH'(x) * PROD_WIDTH'(y);

   // accumulate or restart
   always_comb begin
      prod_ext = ACC_WIDTH'(prod_ff);
      base     = ctl_ff.first ? '0 : acc_ff;
      acc_in   = ctl_ff.subtract ? (base - prod_ext) : (base + prod_ext);
   end

   // control stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   // product and accumulator registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// File: src/determinant_4x4.sv
`default_nettype none

// Exact 4x4 integer determinant. Sixteen signed elements are taken in
// row-major order, one per cycle while req_stall is low, and kept in a
// store with one write and two read ports. The accepted sixteenth element
// starts a 28-step microcode run on one shared multiply-accumulate unit:
// six 2x2 minors, four 3x3 minors, then the cofactor expansion along row 0.
// req_stall stays high through the run until the determinant is written,
// and the single multiplier does one product per cycle of the run. The result
// waits in an output register; elements of the next matrix are taken while
// it waits, and only the closing element stalls until it has been taken.
// Only the low ELEMENT_WIDTH bits of each element are used, sign-extended.

`include "determinant_4x4_macros.svh"

module determinant_4x4
   import det4_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [13:0]    req_element_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [DET_WIDTH-1:0] rsp_determinant
);

   // sequencer states
   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam logic [ADDR_WIDTH-1:0] LAST_INDEX = ADDR_WIDTH'(NUM_ELEMENTS - 1);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP  = STEP_WIDTH'(NUM_STEPS - 1);

   logic [1:0]                   state_ff, state_in;
   logic [ADDR_WIDTH-1:0]        count_ff, count_in;
   logic [STEP_WIDTH-1:0]        step_ff, step_in;
   step_ctl_type                 code;
   step_ctl_type                 ctl1_ff, ctl1_in;
   step_ctl_type                 ctl2_ff;
   step_ctl_type                 ctl3_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DET_WIDTH-1:0]  rsp_det_ff;
   logic                         accept;

   logic signed [ELEMENT_WIDTH-1:0] matrix_mem [NUM_ELEMENTS];
   logic signed [ELEMENT_WIDTH-1:0] rd_x_ff;
   logic signed [ELEMENT_WIDTH-1:0] rd_y_ff;
   logic signed [TMP_WIDTH-1:0]     tmp_ff [NUM_TMPS];

   logic signed [TMP_WIDTH-1:0]  mac_y;
   mac_ctl_type                  mac_ctl;
   logic signed [ACC_WIDTH-1:0]  acc;

   // input handshake
   assign req_stall = (state_ff != ST_LOAD) || ((count_ff == LAST_INDEX) && rsp_valid_ff);
   assign accept    = req_valid && !req_stall;

   // current microcode word
   assign code = step_code(step_ff);

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      ctl1_in  = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = count_ff + 1'b1;
               if (count_ff == LAST_INDEX) begin
                  state_in = ST_RUN;
                  step_in  = '0;
               end
            end
         end
         ST_RUN: begin
            ctl1_in = code;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (ctl3_ff.valid && ctl3_ff.finish) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // result register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl3_ff.valid && ctl3_ff.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         step_ff      <= '0;
         ctl1_ff      <= '0;
         ctl2_ff      <= '0;
         ctl3_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         ctl1_ff      <= ctl1_in;
         ctl2_ff      <= ctl1_ff;
         ctl3_ff      <= ctl2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // matrix store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (accept) begin
         matrix_mem[count_ff] <= req_element_value[ELEMENT_WIDTH-1:0];
      end
      rd_x_ff <= matrix_mem[code.x_addr];
      rd_y_ff <= matrix_mem[code.y_addr];
   end

   // second operand: scratch minor or matrix element
   always_comb begin
      mac_y            = ctl1_ff.y_tmp ? tmp_ff[ctl1_ff.y_addr[TMP_IDX_WIDTH-1:0]]
                                       : TMP_WIDTH'(rd_y_ff);
      mac_ctl.valid    = ctl1_ff.valid;
      mac_ctl.first    = ctl1_ff.first;
      mac_ctl.subtract = ctl1_ff.subtract;
   end

   det4_mac u_mac (
      .clock (clock),
      .reset (reset),
      .x     (rd_x_ff),
      .y     (mac_y),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   // write back finished minors and the determinant
   always_ff @(posedge clock) begin
      if (ctl3_ff.valid && ctl3_ff.last) begin
         if (ctl3_ff.finish) begin
            rsp_det_ff <= DET_WIDTH'(acc);
         end else begin
            tmp_ff[ctl3_ff.dest] <= acc[TMP_WIDTH-1:0];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_determinant = rsp_det_ff;

   // checks
   `DET4_ASSERT_IMPL(a_result_slot_free, clock, reset,
                     ctl3_ff.valid && ctl3_ff.finish, !rsp_valid_ff)
   `DET4_ASSERT_NEXT(a_result_follows_finish, clock, reset,
                     ctl3_ff.valid && ctl3_ff.finish, rsp_valid_ff)
   `DET4_ASSERT_NEXT(a_run_after_last_element, clock, reset,
                     accept && (count_ff == LAST_INDEX), state_ff == ST_RUN)
   `DET4_ASSERT_IMPL(a_count_wrapped_in_run, clock, reset,
                     state_ff != ST_LOAD, count_ff == '0)

endmodule

`default_nettype wire
